// ===== hw/rtl/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg: shared widths and types of the line intersection block
// Holds the datapath widths that follow from the coordinate and fraction
// widths, and the flag bundle that travels with each transaction.
// ----------------------------------------------------------------------------
`default_nettype none
package lis_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 32;
  localparam int NLANE      = 2;

  localparam int AB_W   = COORD_BITS + 1;
  localparam int PC_W   = 2 * COORD_BITS;
  localparam int C_W    = 2 * COORD_BITS + 1;
  localparam int SIDE_W = 2 * COORD_BITS + 3;
  localparam int DET_W  = 2 * COORD_BITS + 3;
  localparam int NUM_W  = 3 * COORD_BITS + 3;
  localparam int DIVN_W = NUM_W + FRAC_BITS;
  localparam int REM_W  = ((DIVN_W > DET_W + Q_W) ? DIVN_W : DET_W + Q_W) + 1;

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [DET_W-1:0] den_t;
  typedef logic [Q_W-1:0]   quo_t;

  typedef struct packed {
    logic             crosses;
    logic             parallel;
    logic [NLANE-1:0] neg;
    logic [NLANE-1:0] over;
  } lis_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/line_intersection_with_side_test.sv =====
// ----------------------------------------------------------------------------
// line_intersection_with_side_test: side test and Cramer intersection
// Runs through 6 geometry stages, 32 divider stages (one quotient bit each)
// and one output register stage. One transaction per cycle when out_ready
// does not stall; every stage has its own valid bit.
// Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module line_intersection_with_side_test
  import lis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] in_p1_x,
  input  wire logic [COORD_BITS-1:0] in_p1_y,
  input  wire logic [COORD_BITS-1:0] in_p2_x,
  input  wire logic [COORD_BITS-1:0] in_p2_y,
  input  wire logic [COORD_BITS-1:0] in_p3_x,
  input  wire logic [COORD_BITS-1:0] in_p3_y,
  input  wire logic [COORD_BITS-1:0] in_p4_x,
  input  wire logic [COORD_BITS-1:0] in_p4_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_crosses,
  output logic                       out_parallel,
  output logic signed [Q_W-1:0]      out_meet_x,
  output logic signed [Q_W-1:0]      out_meet_y
);

  // Front end to divider.
  logic       fr_valid, dv_ready;
  rem_t       fr_rem [NLANE];
  den_t       fr_den;
  lis_flags_t fr_flags;

  // Divider to output stage.
  logic       dv_valid, out_adv;
  quo_t       dv_q [NLANE];
  lis_flags_t dv_flags;

  lis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_p1_x   (in_p1_x),
    .in_p1_y   (in_p1_y),
    .in_p2_x   (in_p2_x),
    .in_p2_y   (in_p2_y),
    .in_p3_x   (in_p3_x),
    .in_p3_y   (in_p3_y),
    .in_p4_x   (in_p4_x),
    .in_p4_y   (in_p4_y),
    .out_valid (fr_valid),
    .out_ready (dv_ready),
    .out_rem   (fr_rem),
    .out_den   (fr_den),
    .out_flags (fr_flags)
  );

  lis_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (dv_ready),
    .in_rem    (fr_rem),
    .in_den    (fr_den),
    .in_flags  (fr_flags),
    .out_valid (dv_valid),
    .out_ready (out_adv),
    .out_q     (dv_q),
    .out_flags (dv_flags)
  );

  // The output register takes a new result whenever it is empty or its
  // current transaction is taken in this cycle.
  assign out_adv = !out_valid || out_ready;

  // Saturation: a negative quotient may reach magnitude 2^(Q_W-1), a positive
  // one only 2^(Q_W-1)-1. Parallel lines force both coordinates to zero.
  quo_t meet_nxt [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (dv_flags.parallel) begin
        meet_nxt[l] = '0;
      end else if (dv_flags.neg[l]) begin
        if (dv_flags.over[l] || (dv_q[l][Q_W-1] && (dv_q[l][Q_W-2:0] != '0))) begin
          meet_nxt[l] = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          meet_nxt[l] = Q_W'(-dv_q[l]);
        end
      end else begin
        if (dv_flags.over[l] || dv_q[l][Q_W-1]) begin
          meet_nxt[l] = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          meet_nxt[l] = dv_q[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_crosses  <= dv_flags.crosses;
      out_parallel <= dv_flags.parallel;
      out_meet_x   <= $signed(meet_nxt[0]);
      out_meet_y   <= $signed(meet_nxt[1]);
    end
  end

  // Parallel results always carry a zero meeting point.
  a_parallel_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parallel |-> (out_meet_x == '0) && (out_meet_y == '0))
    else $error("parallel result with nonzero coordinates");

  // Reset empties the output stage.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An empty output stage must let the divider advance.
  a_out_take : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> out_adv)
    else $error("empty output stage stalls the divider");

  // A stalled result stays presented.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_meet_x))
    else $error("stalled result dropped or changed");

endmodule
`default_nettype wire

// ===== hw/rtl/lis_front.sv =====
// ----------------------------------------------------------------------------
// lis_front: geometry front end
// Six stages: line coefficients, side values, determinant, Cramer numerators,
// magnitudes and the overflow check that precedes the divider.
// ----------------------------------------------------------------------------
`default_nettype none
module lis_front
  import lis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] in_p1_x,
  input  wire logic [COORD_BITS-1:0] in_p1_y,
  input  wire logic [COORD_BITS-1:0] in_p2_x,
  input  wire logic [COORD_BITS-1:0] in_p2_y,
  input  wire logic [COORD_BITS-1:0] in_p3_x,
  input  wire logic [COORD_BITS-1:0] in_p3_y,
  input  wire logic [COORD_BITS-1:0] in_p4_x,
  input  wire logic [COORD_BITS-1:0] in_p4_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rem_t                       out_rem [NLANE],
  output den_t                       out_den,
  output lis_flags_t                 out_flags
);

  logic [6:1] v_r;
  logic [7:1] adv;

  assign adv[7] = out_ready;
  for (genvar k = 1; k <= 6; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign in_ready  = adv[1];
  assign out_valid = v_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = $signed(in_p1_x);
  assign y1 = $signed(in_p1_y);
  assign x2 = $signed(in_p2_x);
  assign y2 = $signed(in_p2_y);
  assign x3 = $signed(in_p3_x);
  assign y3 = $signed(in_p3_y);
  assign x4 = $signed(in_p4_x);
  assign y4 = $signed(in_p4_y);

  // Stage 1: coefficients a and b, and the four products behind c.
  logic signed [AB_W-1:0]       a1_1_r, b1_1_r, a2_1_r, b2_1_r;
  logic signed [PC_W-1:0]       y1x4_r, x1y4_r, y2x3_r, x2y3_r;
  logic signed [COORD_BITS-1:0] x2_1_r, y2_1_r, x3_1_r, y3_1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      a1_1_r <= AB_W'(y4) - AB_W'(y1);
      b1_1_r <= AB_W'(x1) - AB_W'(x4);
      a2_1_r <= AB_W'(y3) - AB_W'(y2);
      b2_1_r <= AB_W'(x2) - AB_W'(x3);
      y1x4_r <= PC_W'(y1) * PC_W'(x4);
      x1y4_r <= PC_W'(x1) * PC_W'(y4);
      y2x3_r <= PC_W'(y2) * PC_W'(x3);
      x2y3_r <= PC_W'(x2) * PC_W'(y3);
      x2_1_r <= x2;
      y2_1_r <= y2;
      x3_1_r <= x3;
      y3_1_r <= y3;
    end
  end

  // Stage 2: c terms, side products and determinant products.
  logic signed [AB_W-1:0]   a1_2_r, b1_2_r, a2_2_r, b2_2_r;
  logic signed [C_W-1:0]    c1_2_r, c2_2_r;
  logic signed [SIDE_W-1:0] a1x2_r, b1y2_r, a1x3_r, b1y3_r;
  logic signed [DET_W-1:0]  a1b2_r, a2b1_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      a1_2_r <= a1_1_r;
      b1_2_r <= b1_1_r;
      a2_2_r <= a2_1_r;
      b2_2_r <= b2_1_r;
      c1_2_r <= C_W'(y1x4_r) - C_W'(x1y4_r);
      c2_2_r <= C_W'(y2x3_r) - C_W'(x2y3_r);
      a1x2_r <= SIDE_W'(a1_1_r) * SIDE_W'(x2_1_r);
      b1y2_r <= SIDE_W'(b1_1_r) * SIDE_W'(y2_1_r);
      a1x3_r <= SIDE_W'(a1_1_r) * SIDE_W'(x3_1_r);
      b1y3_r <= SIDE_W'(b1_1_r) * SIDE_W'(y3_1_r);
      a1b2_r <= DET_W'(a1_1_r) * DET_W'(b2_1_r);
      a2b1_r <= DET_W'(a2_1_r) * DET_W'(b1_1_r);
    end
  end

  // Stage 3: side values, determinant and numerator products.
  logic signed [SIDE_W-1:0] s2_r, s3_r;
  logic signed [DET_W-1:0]  det_3_r;
  logic signed [NUM_W-1:0]  b1c2_r, b2c1_r, a2c1_r, a1c2_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s2_r    <= a1x2_r + b1y2_r + SIDE_W'(c1_2_r);
      s3_r    <= a1x3_r + b1y3_r + SIDE_W'(c1_2_r);
      det_3_r <= a1b2_r - a2b1_r;
      b1c2_r  <= NUM_W'(b1_2_r) * NUM_W'(c2_2_r);
      b2c1_r  <= NUM_W'(b2_2_r) * NUM_W'(c1_2_r);
      a2c1_r  <= NUM_W'(a2_2_r) * NUM_W'(c1_2_r);
      a1c2_r  <= NUM_W'(a1_2_r) * NUM_W'(c2_2_r);
    end
  end

  // Stage 4: flags and the signed numerators.
  logic                    crosses_4_r, parallel_4_r;
  logic signed [DET_W-1:0] det_4_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic                    same_side;

  // A zero side value never counts as being on one side.
  assign same_side = (s2_r != '0) && (s3_r != '0) && (s2_r[SIDE_W-1] == s3_r[SIDE_W-1]);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      crosses_4_r  <= !same_side;
      parallel_4_r <= (det_3_r == '0);
      det_4_r      <= det_3_r;
      nx_r         <= b1c2_r - b2c1_r;
      ny_r         <= a2c1_r - a1c2_r;
    end
  end

  // Stage 5: magnitudes and quotient signs.
  logic             crosses_5_r, parallel_5_r;
  logic [NLANE-1:0] neg_5_r;
  logic [NUM_W-1:0] nmag_r [NLANE];
  den_t             dmag_5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      crosses_5_r  <= crosses_4_r;
      parallel_5_r <= parallel_4_r;
      neg_5_r[0]   <= nx_r[NUM_W-1] ^ det_4_r[DET_W-1];
      neg_5_r[1]   <= ny_r[NUM_W-1] ^ det_4_r[DET_W-1];
      nmag_r[0]    <= nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
      nmag_r[1]    <= ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
      dmag_5_r     <= det_4_r[DET_W-1] ? DET_W'(-det_4_r) : DET_W'(det_4_r);
    end
  end

  // Stage 6: scaled dividend and the check for a quotient wider than Q_W bits.
  rem_t       rem_6_r [NLANE];
  den_t       den_6_r;
  lis_flags_t flags_6_r;
  rem_t       num_s [NLANE];
  rem_t       den_hi;

  assign den_hi = rem_t'(dmag_5_r) << Q_W;
  for (genvar l = 0; l < NLANE; l++) begin : g_scale
    assign num_s[l] = rem_t'(nmag_r[l]) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int l = 0; l < NLANE; l++) begin
        rem_6_r[l]        <= num_s[l];
        flags_6_r.over[l] <= (num_s[l] >= den_hi);
      end
      den_6_r            <= dmag_5_r;
      flags_6_r.crosses  <= crosses_5_r;
      flags_6_r.parallel <= parallel_5_r;
      flags_6_r.neg      <= neg_5_r;
    end
  end

  assign out_rem   = rem_6_r;
  assign out_den   = den_6_r;
  assign out_flags = flags_6_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lis_div.sv =====
// ----------------------------------------------------------------------------
// lis_div: pipelined restoring divider, two lanes
// One quotient bit per stage, most significant first, for both coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
module lis_div
  import lis_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rem_t       in_rem [NLANE],
  input  wire den_t       in_den,
  input  wire lis_flags_t in_flags,
  output logic            out_valid,
  input  wire logic       out_ready,
  output quo_t            out_q [NLANE],
  output lis_flags_t      out_flags
);

  logic [Q_W:1]   v_r;
  logic [Q_W+1:1] adv;
  rem_t           rem_r [1:Q_W][NLANE];
  quo_t           q_r   [1:Q_W][NLANE];
  den_t           den_r [1:Q_W];
  lis_flags_t     flg_r [1:Q_W];

  assign adv[Q_W+1] = out_ready;
  assign in_ready   = adv[1];
  assign out_valid  = v_r[Q_W];
  assign out_q      = q_r[Q_W];
  assign out_flags  = flg_r[Q_W];

  for (genvar j = 1; j <= Q_W; j++) begin : g_stg
    localparam int BIT = Q_W - j;
    logic       src_v;
    rem_t       src_rem [NLANE];
    quo_t       src_q   [NLANE];
    den_t       src_den;
    lis_flags_t src_flg;

    if (j == 1) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = in_rem;
      assign src_den = in_den;
      assign src_flg = in_flags;
      for (genvar l = 0; l < NLANE; l++) begin : g_z
        assign src_q[l] = '0;
      end
    end else begin : g_next
      assign src_v   = v_r[j-1];
      assign src_rem = rem_r[j-1];
      assign src_q   = q_r[j-1];
      assign src_den = den_r[j-1];
      assign src_flg = flg_r[j-1];
    end

    assign adv[j] = !v_r[j] || adv[j+1];

    logic [REM_W:0] trial [NLANE];
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      assign trial[l] = {1'b0, src_rem[l]} - {1'b0, rem_t'(src_den) << BIT};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv[j]) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        den_r[j] <= src_den;
        flg_r[j] <= src_flg;
        for (int l = 0; l < NLANE; l++) begin
          rem_r[j][l] <= trial[l][REM_W] ? src_rem[l] : trial[l][REM_W-1:0];
          q_r[j][l]   <= src_q[l] | (quo_t'(!trial[l][REM_W]) << BIT);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for line_intersection_with_side_test
// A driver and a monitor run as clocked processes. A local model predicts the
// side-test flag, the parallel flag and the Q16.16 meeting point for every
// accepted input transaction. The monitor checks each output transaction
// against the oldest prediction, one field at a time.
// ----------------------------------------------------------------------------
module testbench;
  import lis_pkg::*;

  // One set of four points. When hold_first is set, the driver waits until
  // every result in flight has come back before it offers this transaction.
  typedef struct {
    logic [COORD_BITS-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y;
    bit                    hold_first;
  } segment_pair_t;

  typedef struct {
    logic                crosses;
    logic                parallel;
    logic signed [Q_W-1:0] meet_x;
    logic signed [Q_W-1:0] meet_y;
  } meet_point_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] in_p1_x = '0, in_p1_y = '0, in_p2_x = '0, in_p2_y = '0;
  logic [COORD_BITS-1:0] in_p3_x = '0, in_p3_y = '0, in_p4_x = '0, in_p4_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_crosses, out_parallel;
  logic signed [Q_W-1:0] out_meet_x, out_meet_y;

  segment_pair_t pending_pairs[$];
  meet_point_t   expected_points[$];
  segment_pair_t offered;
  int            pairs_sent = 0;
  int            points_seen = 0;
  int            mismatches = 0;
  int            cycles = 0;

  always #5 clk = ~clk;

  line_intersection_with_side_test u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_p1_x     (in_p1_x),
    .in_p1_y     (in_p1_y),
    .in_p2_x     (in_p2_x),
    .in_p2_y     (in_p2_y),
    .in_p3_x     (in_p3_x),
    .in_p3_y     (in_p3_y),
    .in_p4_x     (in_p4_x),
    .in_p4_y     (in_p4_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_crosses (out_crosses),
    .out_parallel(out_parallel),
    .out_meet_x  (out_meet_x),
    .out_meet_y  (out_meet_y)
  );

  // Divides num * 2^16 by den, truncating toward zero, and clamps the
  // quotient into the signed 32-bit range. Wide enough that nothing wraps.
  function automatic logic signed [Q_W-1:0] fixed_quotient(longint num, longint den);
    logic signed [127:0] wide_num, wide_den, quo;
    wide_num = num;
    wide_den = den;
    wide_num = wide_num <<< FRAC_BITS;
    quo = wide_num / wide_den;
    if (quo > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (quo < -128'sh80000000) return 32'sh80000000;
    return quo[Q_W-1:0];
  endfunction

  // Line A runs through p1 and p4, line B through p2 and p3. The side test
  // uses the implicit form a*x + b*y + c of line A; a zero side value (a point
  // on the line) never counts as being on the same side.
  function automatic meet_point_t predict_meet(segment_pair_t s);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint a1, b1, c1, a2, b2, c2, side2, side3, det;
    meet_point_t r;
    x1 = longint'($signed(s.p1_x)); y1 = longint'($signed(s.p1_y));
    x2 = longint'($signed(s.p2_x)); y2 = longint'($signed(s.p2_y));
    x3 = longint'($signed(s.p3_x)); y3 = longint'($signed(s.p3_y));
    x4 = longint'($signed(s.p4_x)); y4 = longint'($signed(s.p4_y));
    a1 = y4 - y1; b1 = x1 - x4; c1 = y1 * x4 - x1 * y4;
    a2 = y3 - y2; b2 = x2 - x3; c2 = y2 * x3 - x2 * y3;
    side2 = a1 * x2 + b1 * y2 + c1;
    side3 = a1 * x3 + b1 * y3 + c1;
    r.crosses = !((side2 > 0 && side3 > 0) || (side2 < 0 && side3 < 0));
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      r.parallel = 1'b1;
      r.meet_x = '0;
      r.meet_y = '0;
    end else begin
      r.parallel = 1'b0;
      r.meet_x = fixed_quotient(b1 * c2 - b2 * c1, det);
      r.meet_y = fixed_quotient(a2 * c1 - a1 * c2, det);
    end
    return r;
  endfunction

  function automatic segment_pair_t make_pair(int x1, int y1, int x2, int y2,
                                               int x3, int y3, int x4, int y4);
    segment_pair_t s;
    s.p1_x = x1[15:0]; s.p1_y = y1[15:0]; s.p2_x = x2[15:0]; s.p2_y = y2[15:0];
    s.p3_x = x3[15:0]; s.p3_y = y3[15:0]; s.p4_x = x4[15:0]; s.p4_y = y4[15:0];
    s.hold_first = 1'b0;
    return s;
  endfunction

  function automatic int rand_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Driver. A transaction is accepted on an edge where in_valid and in_ready
  // were both high; its prediction is queued at that same edge. Idle gaps
  // are skipped for a middle stretch of the run.
  always @(posedge clk) begin
    bit calm;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_points.push_back(predict_meet(offered));
        pairs_sent++;
      end
      if (!in_valid || in_ready) begin
        calm = (pairs_sent >= 700 && pairs_sent < 1000);
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 31) &&
            (!pending_pairs[0].hold_first ||
             (expected_points.size() == 0 && !(in_valid && in_ready)))) begin
          offered = pending_pairs.pop_front();
          in_valid <= 1'b1;
          in_p1_x <= offered.p1_x; in_p1_y <= offered.p1_y;
          in_p2_x <= offered.p2_x; in_p2_y <= offered.p2_y;
          in_p3_x <= offered.p3_x; in_p3_y <= offered.p3_y;
          in_p4_x <= offered.p4_x; in_p4_y <= offered.p4_y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Back-pressure is random outside a calm stretch of results.
  always @(posedge clk) begin
    meet_point_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result transaction");
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (out_crosses !== want.crosses) begin
            $error("crosses: expected %0d, got %0d", want.crosses, out_crosses);
            mismatches++;
          end
          if (out_parallel !== want.parallel) begin
            $error("parallel: expected %0d, got %0d", want.parallel, out_parallel);
            mismatches++;
          end
          if (out_meet_x !== want.meet_x) begin
            $error("meet_x: expected %0d, got %0d", want.meet_x, out_meet_x);
            mismatches++;
          end
          if (out_meet_y !== want.meet_y) begin
            $error("meet_y: expected %0d, got %0d", want.meet_y, out_meet_y);
            mismatches++;
          end
        end
        points_seen++;
      end
      out_ready <= (points_seen >= 300 && points_seen < 600) || $urandom_range(99) >= 31;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    segment_pair_t s;
    int dx, dy, k, x1, y1, x4, y4, x2, y2;

    // Directed cases: crossing segments, the same side, a point on line A,
    // parallel and fully degenerate lines, overflowing quotients, extremes.
    pending_pairs.push_back(make_pair(0, 0, 0, 10, 10, 0, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 5, 1, 9, 2, 10, 0));
    pending_pairs.push_back(make_pair(0, 0, 5, 0, 5, 7, 10, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 10, 1, 10, 0));
    pending_pairs.push_back(make_pair(0, 0, 3, 3, 7, 7, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767,
                                      32767, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                      32767, -32768, -32768, 32767));
    pending_pairs.push_back(make_pair(-32768, 0, -32768, 1, 32767, 0, 32767, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 32767, 2, 32767, 1));
    pending_pairs.push_back(make_pair(-32768, -32767, 32767, 32766,
                                      -32768, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(0, 0, -32768, 1, 32767, 0, 1, 0));
    pending_pairs.push_back(make_pair(1, 3, 2, -5, 7, 11, -3, 4));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(0, 0, 1, 1, 2, 2, 3, 3));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(0, 0, 1, 0, -1, 0, 0, 1));

    // Random part: full-range points, small coordinates of at most 200 in
    // magnitude, and constructed parallel or collinear pairs.
    for (int n = 0; n < 1750; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          s.p1_x = COORD_BITS'($urandom); s.p1_y = COORD_BITS'($urandom);
          s.p2_x = COORD_BITS'($urandom); s.p2_y = COORD_BITS'($urandom);
          s.p3_x = COORD_BITS'($urandom); s.p3_y = COORD_BITS'($urandom);
          s.p4_x = COORD_BITS'($urandom); s.p4_y = COORD_BITS'($urandom);
          s.hold_first = 1'b0;
        end
        4, 5, 6, 7: begin
          s = make_pair(rand_coord(200), rand_coord(200), rand_coord(200), rand_coord(200),
                        rand_coord(200), rand_coord(200), rand_coord(200), rand_coord(200));
        end
        default: begin
          x1 = rand_coord(1000); y1 = rand_coord(1000);
          dx = rand_coord(100); dy = rand_coord(100);
          x4 = x1 + dx; y4 = y1 + dy;
          x2 = rand_coord(1000); y2 = rand_coord(1000);
          k = rand_coord(5);
          s = make_pair(x1, y1, x2, y2, x2 + k * dx, y2 + k * dy, x4, y4);
        end
      endcase
      if (n == 600 || n == 1300) s.hold_first = 1'b1;
      pending_pairs.push_back(s);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_pairs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_points.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
